### hdl/bf7_pkg.sv
// ----------------------------------------------------------------------------
// bf7_pkg
// Shared constants, types and helpers for the 7x7 box filter stream block.
// ----------------------------------------------------------------------------
package bf7_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int WINDOW     = 7;

    localparam int NLINES = WINDOW - 1;
    localparam int HALF   = WINDOW / 2;
    localparam int AREA   = WINDOW * WINDOW;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CFG_W  = 10;
    localparam int CMP_W  = 16;
    localparam int LS_W   = NLINES * PIX_W;
    localparam int CSUM_W = 11;
    localparam int SUM_W  = 14;
    localparam int OUT_W  = 14;
    localparam int CTR_W  = 9;

    // floor(x / AREA) as (x * DIV_K) >> DIV_SH, exact over the sum range
    localparam int DIV_SH = 20;
    localparam int DIV_K  = (2 ** DIV_SH + AREA - 1) / AREA;
    localparam int DIV_KW = $clog2(DIV_K + 1);
    localparam int PROD_W = SUM_W + DIV_KW;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [CTR_W-1:0] crow;
        logic [CTR_W-1:0] ccol;
    } t_meta;

    // clamp a geometry register to the supported range; zero acts as one
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int max_v);
        logic [CFG_W-1:0] r;
        r = v;
        if (int'(v) > max_v) begin
            r = CFG_W'(max_v);
        end else if (v == '0) begin
            r = CFG_W'(1);
        end
        return r;
    endfunction

endpackage

### hdl/bf7_pix_if.sv
// ----------------------------------------------------------------------------
// bf7_pix_if
// Pixel input channel: valid/ready handshake with pixel and frame_start.
// ----------------------------------------------------------------------------
interface bf7_pix_if import bf7_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

### hdl/bf7_res_if.sv
// ----------------------------------------------------------------------------
// bf7_res_if
// Result channel: valid/ready handshake with filtered value and position.
// ----------------------------------------------------------------------------
interface bf7_res_if import bf7_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] value;
    logic [CTR_W-1:0] center_row;
    logic [CTR_W-1:0] center_col;
    logic             frame_last;

    modport source (output valid, output value, output center_row, output center_col,
                    output frame_last, input ready);
    modport sink   (input valid, input value, input center_row, input center_col,
                    input frame_last, output ready);
endinterface

### hdl/bf7_ram.sv
// ----------------------------------------------------------------------------
// bf7_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bf7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/box_filter_7x7_stream_top.sv
// Pipeline: stage 1, stage 2, stage 3, output register. Throughput: one pixel
//   per cycle unless the output stalls or the line store clear runs; the RAM
//   does one read and one write-back per pixel, with forwarding when the same
//   column repeats. Reset (synchronous, active low): counters, window sum,
//   column history and registers go to defaults; the line store is then
//   cleared to zero, holding the input off until every address is written.
// ----------------------------------------------------------------------------
// box_filter_7x7_stream_top
// Streaming 7x7 box filter: line store read-modify-write, running window sum,
// mean by reciprocal multiply or raw sum output.
// ----------------------------------------------------------------------------
module box_filter_7x7_stream_top import bf7_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bf7_pix_if.sink              i_pix,
    bf7_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic             r_cfg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(512);
            r_cfg_height <= CFG_W'(512);
            r_cfg_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_MODE:   r_cfg_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] w_width;
    logic [CFG_W-1:0] w_height;

    assign w_width  = eff_dim(r_cfg_width, MAX_WIDTH);
    assign w_height = eff_dim(r_cfg_height, MAX_HEIGHT);

    // clear the line store after reset; hold the input off until done
    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= COL_W'(r_clr_addr + COL_W'(1));
            if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // pipeline advance: everything moves when the output register frees up
    logic r_out_valid;
    logic w_adv;
    logic w_accept;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_pix.ready = w_adv && !r_clr_busy;
    assign w_accept    = i_pix.valid && w_adv && !r_clr_busy;

    // position of the incoming pixel
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] w_row_raw;
    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_col;
    logic             w_row_last;
    logic             w_col_last;
    t_meta            w_meta;

    always_comb begin
        w_row_raw = i_pix.frame_start ? '0 : r_row;
        w_col     = i_pix.frame_start ? '0 : r_col;
        w_row     = (CMP_W'(w_row_raw) >= CMP_W'(w_height)) ? '0 : w_row_raw;
        w_row_last = (CMP_W'(w_row) + CMP_W'(1)) >= CMP_W'(w_height);
        w_col_last = (CMP_W'(w_col) + CMP_W'(1)) >= CMP_W'(w_width);
        w_meta.emit = (CMP_W'(w_row) >= CMP_W'(WINDOW - 1))
                   && (CMP_W'(w_col) >= CMP_W'(WINDOW - 1))
                   && (CMP_W'(w_col) <  CMP_W'(w_width));
        w_meta.last = w_row_last && w_col_last;
        w_meta.crow = CTR_W'(w_row - ROW_W'(HALF));
        w_meta.ccol = CTR_W'(w_col - COL_W'(HALF));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (w_col_last) begin
                r_col <= '0;
                r_row <= w_row_last ? '0 : ROW_W'(w_row + ROW_W'(1));
            end else begin
                r_col <= COL_W'(w_col + COL_W'(1));
                r_row <= w_row;
            end
        end
    end

    // stage 1: line store data back from the RAM
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    t_meta            r_s1_meta;
    logic             r_fwd;
    logic [LS_W-1:0]  r_fwd_data;
    logic [LS_W-1:0]  w_ram_rdata;
    logic [LS_W-1:0]  w_lines;
    logic [LS_W-1:0]  w_lines_new;
    logic [CSUM_W-1:0] w_csum;
    logic             w_ram_we;
    logic [COL_W-1:0] w_ram_waddr;
    logic [LS_W-1:0]  w_ram_wdata;

    assign w_ram_we    = r_clr_busy || (r_s1_valid && w_adv);
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : r_s1_col;
    assign w_ram_wdata = r_clr_busy ? '0 : w_lines_new;

    bf7_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_col),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        w_lines     = r_fwd ? r_fwd_data : w_ram_rdata;
        // oldest row sits in the low byte; shift down and append the new pixel
        w_lines_new = {r_s1_px, w_lines[LS_W-1:PIX_W]};
        w_csum      = CSUM_W'(r_s1_px);
        for (int k = 0; k < NLINES; k++) begin
            w_csum = w_csum + CSUM_W'(w_lines[k*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            // the read at this edge misses the write of the same column
            r_fwd      <= r_s1_valid && (r_s1_col == w_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px    <= i_pix.pixel;
            r_s1_col   <= w_col;
            r_s1_meta  <= w_meta;
            r_fwd_data <= w_lines_new;
        end
    end

    // stage 2: column sum into the running window
    logic              r_s2_valid;
    logic [CSUM_W-1:0] r_s2_csum;
    t_meta             r_s2_meta;
    logic [CSUM_W-1:0] r_hist [WINDOW];
    logic [SUM_W-1:0]  r_wsum;
    logic [SUM_W-1:0]  w_wsum_new;

    assign w_wsum_new = SUM_W'(r_wsum + SUM_W'(r_s2_csum) - SUM_W'(r_hist[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_s2_csum <= w_csum;
            r_s2_meta <= r_s1_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_hist[k] <= '0;
            end
        end else if (w_adv && r_s2_valid) begin
            r_wsum <= w_wsum_new;
            for (int k = 0; k < WINDOW - 1; k++) begin
                r_hist[k] <= r_hist[k+1];
            end
            r_hist[WINDOW-1] <= r_s2_csum;
        end
    end

    // stage 3: window sum of an item that completes a window
    logic             r_s3_valid;
    logic [SUM_W-1:0] r_s3_sum;
    t_meta            r_s3_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            // drop border items here
            r_s3_valid <= r_s2_valid && r_s2_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_s3_sum  <= w_wsum_new;
            r_s3_meta <= r_s2_meta;
        end
    end

    // output register: mean by reciprocal multiply, or raw sum
    logic [PROD_W-1:0] w_prod;
    logic [OUT_W-1:0]  w_value;
    logic [OUT_W-1:0]  r_out_value;
    t_meta             r_out_meta;

    assign w_prod  = PROD_W'(r_s3_sum) * PROD_W'(DIV_K);
    assign w_value = r_cfg_mode ? OUT_W'(r_s3_sum) : OUT_W'(w_prod >> DIV_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s3_valid) begin
            r_out_value <= w_value;
            r_out_meta  <= r_s3_meta;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_out_value;
    assign o_res.center_row = r_out_meta.crow;
    assign o_res.center_col = r_out_meta.ccol;
    assign o_res.frame_last = r_out_meta.last;

endmodule

### sim/box_filter_7x7_stream_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_7x7_stream_top_tb
// Streams raster frames through the 7x7 box filter under random source gaps
// and sink stalls. Window sums, means, centre positions and frame-last flags
// are predicted per pixel and checked against every result in order.
// ----------------------------------------------------------------------------
module box_filter_7x7_stream_top_tb import bf7_pkg::*; ;

    localparam int LIMIT         = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_ITEMS    = 500;
    localparam int FILL_RANDOM   = -1;
    localparam int FILL_EXTREME  = -2;
    localparam int NO_TYPED      = -1;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic [CTR_W-1:0] crow;
        logic [CTR_W-1:0] ccol;
        logic             last;
    } t_win_result;

    typedef struct {
        int width;
        int height;
        int sum_mode;
        int npix;
        int fill;
        int lead_fs;
        int want;
    } t_frame_case;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    bf7_pix_if pix_ch ();
    bf7_res_if res_ch ();

    box_filter_7x7_stream_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // filter state as the block should hold it
    logic [PIX_W-1:0] row_buf [NLINES][MAX_WIDTH];
    int unsigned      col_sums [WINDOW];
    int unsigned      win_total;
    int unsigned      next_row;
    int unsigned      next_col;
    logic [CFG_W-1:0] set_width;
    logic [CFG_W-1:0] set_height;
    logic             set_sum_mode;

    t_win_result window_results_due [$];
    int          typed_value = NO_TYPED;
    int          results_seen = 0;
    int          pixels_sent = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    int          cycle_count = 0;

    // directed frames: extremes, clamping, tiny geometry, mid-frame changes
    t_frame_case frame_cases [17] = '{
        // first frame after reset, no frame_start
        '{7,    7,    0, 49,   200,          0, 200},
        '{7,    7,    1, 49,   255,          1, 12495},
        // runs past the frame end into a second frame
        '{7,    7,    1, 98,   FILL_RANDOM,  1, NO_TYPED},
        // oversized height clamps to the maximum: climb one row per pixel
        '{1,    1023, 1, 505,  FILL_RANDOM,  1, NO_TYPED},
        // oversized width clamps to the maximum: one full row, then wrap
        '{1023, 1023, 1, 512,  255,          0, NO_TYPED},
        // finish the clamped frame on a narrow width
        '{7,    1023, 1, 42,   FILL_EXTREME, 0, NO_TYPED},
        '{8,    7,    0, 56,   255,          1, 255},
        '{6,    7,    0, 42,   FILL_RANDOM,  1, NO_TYPED},
        '{7,    6,    0, 42,   FILL_RANDOM,  1, NO_TYPED},
        '{0,    0,    1, 6,    FILL_EXTREME, 1, NO_TYPED},
        '{9,    8,    0, 72,   FILL_EXTREME, 1, NO_TYPED},
        '{10,   9,    1, 90,   128,          1, 6272},
        // stop at row 5, column 10, then shrink the width under the position
        '{12,   10,   0, 70,   FILL_RANDOM,  1, NO_TYPED},
        '{8,    10,   0, 80,   FILL_RANDOM,  0, NO_TYPED},
        // stop at row 10, then shrink the height below the current row
        '{10,   20,   1, 100,  FILL_RANDOM,  1, NO_TYPED},
        '{10,   8,    1, 30,   FILL_RANDOM,  0, NO_TYPED},
        '{10,   8,    0, 50,   FILL_EXTREME, 0, NO_TYPED}
    };

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic int pick_dim();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 6);
        end
        return $urandom_range(7, 14);
    endfunction

    task automatic predict_window_result(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned csum;
        t_win_result due;
        w = clamp_dim(set_width, MAX_WIDTH);
        h = clamp_dim(set_height, MAX_HEIGHT);
        if (fs) begin
            next_row = 0;
            next_col = 0;
        end
        r = (next_row >= h) ? 0 : next_row;
        c = next_col;
        csum = px;
        if (c < MAX_WIDTH) begin
            for (int k = 0; k < NLINES; k++) begin
                csum += row_buf[k][c];
            end
            for (int k = 0; k < NLINES - 1; k++) begin
                row_buf[k][c] = row_buf[k + 1][c];
            end
            row_buf[NLINES - 1][c] = px;
        end
        // drop the oldest column sum, add the new one
        win_total = win_total + csum - col_sums[0];
        for (int k = 0; k < WINDOW - 1; k++) begin
            col_sums[k] = col_sums[k + 1];
        end
        col_sums[WINDOW - 1] = csum;
        if (r >= WINDOW - 1 && c >= WINDOW - 1 && c < w) begin
            due.value = set_sum_mode ? OUT_W'(win_total) : OUT_W'(win_total / AREA);
            if (typed_value != NO_TYPED) begin
                due.value = OUT_W'(typed_value);
            end
            due.crow = CTR_W'(r - HALF);
            due.ccol = CTR_W'(c - HALF);
            due.last = (r + 1 >= h) && (c + 1 >= w);
            window_results_due.push_back(due);
        end
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
            next_row = r;
        end
    endtask

    initial begin
        for (int k = 0; k < NLINES; k++) begin
            for (int c = 0; c < MAX_WIDTH; c++) begin
                row_buf[k][c] = '0;
            end
        end
        for (int k = 0; k < WINDOW; k++) begin
            col_sums[k] = 0;
        end
        win_total    = 0;
        next_row     = 0;
        next_col     = 0;
        set_width    = CFG_W'(MAX_WIDTH);
        set_height   = CFG_W'(MAX_HEIGHT);
        set_sum_mode = 1'b0;
    end

    // sample both channels mid-cycle, where every handshake signal is settled
    always @(negedge i_clk) begin : watch_ports
        t_win_result want_r;
        if (i_rst_n === 1'b1) begin
            if (pix_ch.valid && pix_ch.ready) begin
                predict_window_result(pix_ch.pixel, pix_ch.frame_start);
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (window_results_due.size() == 0) begin
                    $display("%0t: result with nothing due: value %0d row %0d col %0d last %0b",
                             $time, res_ch.value, res_ch.center_row, res_ch.center_col,
                             res_ch.frame_last);
                    mismatches++;
                end else begin
                    want_r = window_results_due.pop_front();
                    if (res_ch.value !== want_r.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want_r.value, res_ch.value);
                        mismatches++;
                    end
                    if (res_ch.center_row !== want_r.crow) begin
                        $display("%0t: center_row mismatch: expected %0d, actual %0d",
                                 $time, want_r.crow, res_ch.center_row);
                        mismatches++;
                    end
                    if (res_ch.center_col !== want_r.ccol) begin
                        $display("%0t: center_col mismatch: expected %0d, actual %0d",
                                 $time, want_r.ccol, res_ch.center_col);
                        mismatches++;
                    end
                    if (res_ch.frame_last !== want_r.last) begin
                        $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                                 $time, want_r.last, res_ch.frame_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side: stall patterns by segment, plus one long hold under load
    initial begin : result_sink
        int  seg;
        int  mode;
        int  phase;
        bit  held;
        held  = 1'b0;
        phase = 0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(1, 64);
            for (int k = 0; k < seg; k++) begin
                @(posedge i_clk);
                if (!held && results_seen >= 200) begin
                    // hold off while the source keeps offering items
                    held = 1'b1;
                    res_ch.ready <= 1'b0;
                    repeat (400) @(posedge i_clk);
                end
                phase++;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: res_ch.ready <= (phase % 4 == 0);
                    default: res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  set_width = val;
            CFG_HEIGHT: set_height = val;
            CFG_MODE:   set_sum_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic load_geometry(input int w, input int h, input int sum_mode);
        cfg_write(CFG_WIDTH, CFG_W'(w));
        cfg_write(CFG_HEIGHT, CFG_W'(h));
        cfg_write(CFG_MODE, CFG_W'(sum_mode));
    endtask

    // drop valid, wait out every due result and the border pixels in flight
    task automatic settle_block();
        pix_ch.valid <= 1'b0;
        while (window_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int gap;
        bit took;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= px;
        pix_ch.frame_start <= fs;
        do begin
            @(negedge i_clk);
            took = pix_ch.ready;
            @(posedge i_clk);
        end while (!took);
        pixels_sent++;
    endtask

    task automatic stream_pixels(input int count, input int fill, input bit lead_fs,
                                 input bit noisy);
        logic [PIX_W-1:0] px;
        logic             fs;
        for (int n = 0; n < count; n++) begin
            if (fill == FILL_EXTREME || (fill == FILL_RANDOM && $urandom_range(0, 7) == 0)) begin
                px = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end else if (fill == FILL_RANDOM) begin
                px = PIX_W'($urandom_range(0, 255));
            end else begin
                px = PIX_W'(fill);
            end
            fs = (n == 0 && lead_fs) || (noisy && $urandom_range(0, 15) == 0);
            send_pixel(px, fs);
        end
    endtask

    initial begin : stimulus
        int pick;
        int w;
        int h;
        int sent_mark;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_WIDTH;
        cfg_data           <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel       <= '0;
        pix_ch.frame_start <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (frame_cases[n]) begin
            settle_block();
            load_geometry(frame_cases[n].width, frame_cases[n].height, frame_cases[n].sum_mode);
            typed_value = frame_cases[n].want;
            stream_pixels(frame_cases[n].npix, frame_cases[n].fill,
                          frame_cases[n].lead_fs != 0, 1'b0);
        end
        typed_value = NO_TYPED;

        sent_mark = pixels_sent;
        while (pixels_sent - sent_mark < RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            settle_block();
            if (pick <= 6) begin
                // whole frame, or a frame cut short
                load_geometry(pick_dim(), pick_dim(), $urandom_range(0, 1));
                w = clamp_dim(set_width, MAX_WIDTH) * clamp_dim(set_height, MAX_HEIGHT);
                if (pick == 6 && w > 1) begin
                    w = $urandom_range(1, w - 1);
                end
                stream_pixels(w, FILL_RANDOM, 1'b1, 1'b0);
            end else if (pick == 7) begin
                // change geometry mid-frame and carry on without frame_start
                w = $urandom_range(0, 20);
                h = $urandom_range(0, 20);
                load_geometry(w, h, $urandom_range(0, 1));
                stream_pixels($urandom_range(1, 60), FILL_RANDOM, 1'b0, 1'b0);
            end else begin
                stream_pixels($urandom_range(20, 80), FILL_RANDOM, 1'b0, 1'b1);
            end
        end

        settle_block();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
